// ===== hw/rtl/nsfc_pkg.sv =====
// Shared types, constants and register codes for the NMEA sentence filter and capture block.
`default_nettype none

package nsfc_pkg;

  // Capture buffer size and longest header pattern.
  localparam int unsigned CaptureDepth = 64;
  localparam int unsigned PatternMax   = 8;

  // Write position reaches at most the capture depth (64).
  localparam int unsigned WposW    = 7;
  // Byte select into the 64-bit header pattern register.
  localparam int unsigned PatIdxW  = 3;

  // Request queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;

  // Characters of interest.
  localparam logic [7:0] Wildcard    = 8'h2A;
  localparam logic [7:0] LineFeed    = 8'h0A;
  localparam logic [7:0] CarriageRet = 8'h0D;
  localparam logic [7:0] Comma       = 8'h2C;
  localparam logic [7:0] ZeroChar    = 8'h30;

  // Register reset values: "$G*RMC", six bytes.
  localparam logic [63:0] HeaderPatternRst = 64'h0000_434D_522A_4724;
  localparam logic [3:0]  HeaderLengthRst  = 4'd6;

  // Request kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindArm  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderPattern = 1'b0,
    CfgHeaderLength  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       overrun;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] stored_byte;
    logic [5:0] position;
    logic       message_done;
  } result_t;

  // One queue entry: the results a single request causes (one or two).
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nsfc_front.sv =====
// Front part: takes requests, runs the header match and capture rules, queues results.
`default_nettype none

module nsfc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  input  wire  nsfc_pkg::in_item_t     item_i,
  input  wire                          cfg_valid_i,
  input  wire  [nsfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire  [63:0]                  cfg_data_i,
  output logic                         cfg_ready_o,
  input  wire                          q_full_i,
  output logic                         q_wr_o,
  output nsfc_pkg::entry_t             q_entry_o
);

  logic [63:0]                 pattern_q, pattern_d;
  logic [3:0]                  length_q, length_d;
  logic                        armed_q, armed_d;
  logic [nsfc_pkg::WposW-1:0]  wpos_q, wpos_d;
  logic [7:0]                  prev_q, prev_d;

  logic                        accept;
  logic [3:0]                  hlen;
  logic [7:0]                  b;
  logic [nsfc_pkg::WposW-1:0]  wp;
  logic [nsfc_pkg::WposW-1:0]  wp1;
  logic [7:0]                  pat;
  logic                        ins;
  logic                        wr;
  logic                        eol;
  nsfc_pkg::result_t           r_ins;
  nsfc_pkg::result_t           r_byte;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full_i;

  // Clamp header length to 1..PatternMax.
  always_comb begin
    if (length_q == 4'd0) begin
      hlen = 4'd1;
    end else if (length_q > 4'(nsfc_pkg::PatternMax)) begin
      hlen = 4'(nsfc_pkg::PatternMax);
    end else begin
      hlen = length_q;
    end
  end

  always_comb begin
    pattern_d = pattern_q;
    length_d  = length_q;
    if (cfg_valid_i) begin
      case (nsfc_pkg::cfg_idx_e'(cfg_index_i))
        nsfc_pkg::CfgHeaderPattern: pattern_d = cfg_data_i;
        nsfc_pkg::CfgHeaderLength:  length_d  = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    armed_d   = armed_q;
    wpos_d    = wpos_q;
    prev_d    = prev_q;
    q_wr_o    = 1'b0;
    q_entry_o = '0;

    // Overrun restarts capture and zeroes the byte.
    b   = item_i.overrun ? 8'h00 : item_i.rx_byte;
    wp  = item_i.overrun ? '0 : wpos_q;
    pat = pattern_q[8*wp[nsfc_pkg::PatIdxW-1:0] +: 8];

    ins = (prev_q == nsfc_pkg::Comma) && (b == nsfc_pkg::Comma)
          && (wp < nsfc_pkg::WposW'(nsfc_pkg::CaptureDepth));
    wp1 = ins ? wp + 1'b1 : wp;
    wr  = wp1 < nsfc_pkg::WposW'(nsfc_pkg::CaptureDepth);
    eol = (b == nsfc_pkg::LineFeed) || (b == nsfc_pkg::CarriageRet);

    r_ins  = '{byte_valid: 1'b1, stored_byte: nsfc_pkg::ZeroChar,
               position: wp[5:0], message_done: 1'b0};
    r_byte = '{byte_valid: wr, stored_byte: wr ? b : 8'h00,
               position: wp1[5:0], message_done: eol};

    if (accept) begin
      if (item_i.kind == nsfc_pkg::KindArm) begin
        armed_d = 1'b1;
        wpos_d  = '0;
        prev_d  = 8'h00;
      end else if (armed_q) begin
        if (wp < nsfc_pkg::WposW'(hlen)) begin
          // Header phase: match or restart, dropping the byte.
          if (pat == nsfc_pkg::Wildcard || pat == b) begin
            q_wr_o    = 1'b1;
            q_entry_o.first = '{byte_valid: 1'b1, stored_byte: b,
                                position: wp[5:0], message_done: 1'b0};
            prev_d    = b;
            wpos_d    = wp + 1'b1;
          end else begin
            wpos_d = '0;
          end
        end else begin
          // Capture phase.
          prev_d = wr ? b : (ins ? nsfc_pkg::ZeroChar : prev_q);
          wpos_d = wr ? wp1 + 1'b1 : wp1;
          if (eol) begin
            armed_d = 1'b0;
          end
          if (ins) begin
            r_ins.message_done = eol && !wr;
            q_entry_o.first    = r_ins;
            q_entry_o.second   = r_byte;
            q_entry_o.two      = wr;
            q_wr_o             = 1'b1;
          end else if (wr || eol) begin
            q_entry_o.first = r_byte;
            q_wr_o          = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= nsfc_pkg::HeaderPatternRst;
      length_q  <= nsfc_pkg::HeaderLengthRst;
      armed_q   <= 1'b0;
      wpos_q    <= '0;
      prev_q    <= 8'h00;
    end else begin
      pattern_q <= pattern_d;
      length_q  <= length_d;
      armed_q   <= armed_d;
      wpos_q    <= wpos_d;
      prev_q    <= prev_d;
    end
  end

`ifndef SYNTHESIS
  // Disarm only on an accepted line end that was not an overrun byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(armed_q) |-> $past(accept && item_i.kind == nsfc_pkg::KindByte
      && !item_i.overrun
      && (item_i.rx_byte == nsfc_pkg::LineFeed || item_i.rx_byte == nsfc_pkg::CarriageRet)))
    else $error("front: disarmed without a line end");

  // Write position never runs past the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= nsfc_pkg::WposW'(nsfc_pkg::CaptureDepth))
    else $error("front: write position past capacity");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/nsfc_queue.sv =====
// Short request queue between the front and the back parts.
`default_nettype none

module nsfc_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                wr_i,
  input  wire  nsfc_pkg::entry_t wr_entry_i,
  output logic               full_o,
  input  wire                rd_i,
  output nsfc_pkg::entry_t   rd_entry_o,
  output logic               empty_o
);

  nsfc_pkg::entry_t             mem_q [nsfc_pkg::QueueDepth];
  logic [nsfc_pkg::QPtrW-1:0]   wptr_q, wptr_d;
  logic [nsfc_pkg::QPtrW-1:0]   rptr_q, rptr_d;
  logic [nsfc_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                         do_wr;
  logic                         do_rd;

  assign full_o     = cnt_q == nsfc_pkg::QCntW'(nsfc_pkg::QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign rd_entry_o = mem_q[rptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !empty_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_rd ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nsfc_pkg::QCntW'(nsfc_pkg::QueueDepth))
    else $error("queue: fill count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue: write while full");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/nsfc_back.sv =====
// Back part: splits queued requests into single results and holds them in the output register.
`default_nettype none

module nsfc_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  nsfc_pkg::entry_t head_i,
  input  wire                q_empty_i,
  output logic               q_rd_o,
  input  wire                pop,
  output logic               empty,
  output nsfc_pkg::result_t  result_o
);

  nsfc_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              sel_q, sel_d;
  logic              load;

  assign empty    = !out_valid_q;
  assign result_o = out_q;
  assign load     = !out_valid_q || pop;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    sel_d       = sel_q;
    q_rd_o      = 1'b0;
    if (load && !q_empty_i) begin
      out_d       = sel_q ? head_i.second : head_i.first;
      out_valid_d = 1'b1;
      // Advance to the second result, or retire the entry.
      if (head_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d  = 1'b0;
        q_rd_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

`ifndef SYNTHESIS
  // Mid-entry the head must still be in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> !q_empty_i)
    else $error("back: second result with empty queue");

  // A result without a stored byte only ever marks a line end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.byte_valid) |-> (out_q.message_done && out_q.stored_byte == 8'h00))
    else $error("back: invalid byte result without message end");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sentence_filter_capture_core.sv =====
// Top level of the NMEA sentence header filter and capture block.
`default_nettype none

// NMEA sentence header filter and capture. Push a request each cycle while
// full is low: either an arm request (kind 1), which clears the write position
// and the comma history, or a received UART byte (kind 0). While armed, the
// first header_length bytes must match header_pattern, byte by byte, with 0x2A
// as a wildcard; a mismatch restarts the match at position 0 and drops the
// byte. After the header every byte is captured and reported with its buffer
// position, a '0' is inserted between two consecutive commas, and CR or LF
// ends the message (message_done on its last result) and disarms the block.
// A byte flagged with overrun restarts capture at position 0 and counts as
// 0x00. No byte is written at or beyond a position of 64; a line end seen with
// the buffer full gives one result with byte_valid low. Rate: the front takes
// one request per cycle while full is low, and the output register delivers
// one result per cycle while pop is high; a request's first result is written
// into the queue when the request is accepted and then loaded from the queue
// into the output register, which makes empty fall. A request that inserts a
// '0' yields two results, or just one when the inserted '0' fills the buffer. A
// four-entry queue decouples the two sides, and full rises only when that
// queue is full, so stalls on pop reach push after five requests with results
// (four when the result held in the output register is the first of a pair).
// Write configuration only while the block is idle; cfg_ready_o is always
// high. There is no clearing pass after reset.

module nmea_sentence_filter_capture_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  output logic                         full,
  input  wire  nsfc_pkg::in_item_t     in_item_i,
  output logic                         empty,
  input  wire                          pop,
  output nsfc_pkg::result_t            out_result_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [nsfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire  [63:0]                  cfg_data_i
);

  logic              q_wr;
  logic              q_rd;
  logic              q_empty;
  nsfc_pkg::entry_t  q_wr_entry;
  nsfc_pkg::entry_t  q_head;

  // Front: classify each request and turn it into zero, one or two results.
  nsfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .q_full_i    (full),
    .q_wr_o      (q_wr),
    .q_entry_o   (q_wr_entry)
  );

  // Queue: hold result groups so either side may stall independently.
  nsfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (q_wr_entry),
    .full_o     (full),
    .rd_i       (q_rd),
    .rd_entry_o (q_head),
    .empty_o    (q_empty)
  );

  // Back: hand out one result per cycle through the output register while pop is high.
  nsfc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .result_o  (out_result_o)
  );

endmodule

`default_nettype wire
